// ===== src/jpf_pkg.sv =====
// ----------------------------------------------------------------------------
// jpf_pkg: shared types and constants for the joint pairing filter
// Request and response payloads, tag codes, controller command and status.
// ----------------------------------------------------------------------------
package jpf_pkg;

   localparam int INDEX_W    = 16;
   localparam int FEATURE_W  = 32;
   localparam int POINT_W    = 32;
   localparam int JOINT_W    = 16;
   localparam int COUNTER_W  = 17;
   localparam int INDEX_SPAN = 1 << INDEX_W;

   // entry tag codes
   localparam logic [1:0] TAG_EMPTY    = 2'd0;
   localparam logic [1:0] TAG_PENDING  = 2'd1;
   localparam logic [1:0] TAG_ASSIGNED = 2'd2;

   typedef struct packed {
      logic [INDEX_W-1:0]   joint_index;
      logic [FEATURE_W-1:0] feature_id;
      logic [POINT_W-1:0]   point_id;
   } req_type;

   typedef struct packed {
      logic [JOINT_W-1:0]   assigned_joint;
      logic [FEATURE_W-1:0] out_feature;
      logic [POINT_W-1:0]   out_point;
      logic                 last;
   } rsp_type;

   typedef struct packed {
      logic clear_step;    // clear one tag entry
      logic load;          // take the request, read the table
      logic set_pending;   // hold the point, mark pending
      logic set_assigned;  // mark assigned, store number, advance counter
      logic emit_held;     // emit the held point
      logic emit_now;      // emit the new point with the looked-up number
      logic emit_later;    // emit the new point with the latched number
   } cmd_type;

   typedef struct packed {
      logic       clear_last;
      logic       in_range;
      logic [1:0] tag;
   } status_type;

endpackage

// ===== src/jpf_ctrl.sv =====
// ----------------------------------------------------------------------------
// jpf_ctrl: sequencer of the joint pairing filter
// Runs the tag clearing pass, then takes one request at a time and steers
// the table update and the response emission.
// ----------------------------------------------------------------------------
module jpf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  jpf_pkg::status_type  status,
   output logic                 busy,
   output jpf_pkg::cmd_type     cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_DECIDE = 4'b0100,
      ST_SECOND = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_IDLE;
            // drop indexes beyond the table
            if (status.in_range) begin
               case (status.tag)
                  jpf_pkg::TAG_PENDING: begin
                     cmd.set_assigned = 1'b1;
                     cmd.emit_held    = 1'b1;
                     state_in         = ST_SECOND;
                  end
                  jpf_pkg::TAG_ASSIGNED: begin
                     cmd.emit_now = 1'b1;
                  end
                  default: begin
                     cmd.set_pending = 1'b1;
                  end
               endcase
            end
         end
         ST_SECOND: begin
            cmd.emit_later = 1'b1;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== src/jpf_datapath.sv =====
// ----------------------------------------------------------------------------
// jpf_datapath: table memories, joint counter and response register
// Holds the tag, feature and value stores and builds each response.
// ----------------------------------------------------------------------------
module jpf_datapath #(
   parameter int TABLE_DEPTH = 65536
) (
   input  logic                 clock,
   input  logic                 reset,
   input  jpf_pkg::req_type     req_data,
   input  jpf_pkg::cmd_type     cmd,
   output jpf_pkg::status_type  status,
   output logic                 rsp_strobe,
   output jpf_pkg::rsp_type     rsp_data
);

   localparam int MEM_DEPTH = (TABLE_DEPTH < jpf_pkg::INDEX_SPAN) ?
                              TABLE_DEPTH : jpf_pkg::INDEX_SPAN;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam logic [ADDR_W-1:0] LastAddr = ADDR_W'(MEM_DEPTH - 1);

   logic [1:0]                     tag_mem     [MEM_DEPTH];
   logic [jpf_pkg::FEATURE_W-1:0]  feature_mem [MEM_DEPTH];
   logic [jpf_pkg::POINT_W-1:0]    value_mem   [MEM_DEPTH];

   logic [ADDR_W-1:0]              clear_addr_ff;
   jpf_pkg::req_type               req_ff;
   logic                           in_range_ff;
   logic [1:0]                     tag_rd_ff;
   logic [jpf_pkg::FEATURE_W-1:0]  feat_rd_ff;
   logic [jpf_pkg::POINT_W-1:0]    value_rd_ff;
   logic [jpf_pkg::COUNTER_W-1:0]  next_joint_ff;
   logic [jpf_pkg::JOINT_W-1:0]    joint_ff;
   jpf_pkg::rsp_type               rsp_ff, rsp_in;
   logic                           rsp_strobe_ff, rsp_strobe_in;

   logic [ADDR_W-1:0]              ld_addr, idx_addr, tag_wa;
   logic                           tag_we;
   logic [1:0]                     tag_wd;
   logic [jpf_pkg::JOINT_W-1:0]    joint_sel;
   logic [jpf_pkg::POINT_W-1:0]    value_wd;

   assign ld_addr  = req_data.joint_index[ADDR_W-1:0];
   assign idx_addr = req_ff.joint_index[ADDR_W-1:0];

   assign tag_we = cmd.clear_step | cmd.set_pending | cmd.set_assigned;
   assign tag_wa = cmd.clear_step ? clear_addr_ff : idx_addr;
   assign tag_wd = cmd.set_pending  ? jpf_pkg::TAG_PENDING  :
                   cmd.set_assigned ? jpf_pkg::TAG_ASSIGNED : jpf_pkg::TAG_EMPTY;

   assign value_wd = cmd.set_pending ? req_ff.point_id :
                     jpf_pkg::POINT_W'(next_joint_ff);

   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[tag_wa] <= tag_wd;
      end
      if (cmd.load) begin
         tag_rd_ff <= tag_mem[ld_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.set_pending) begin
         feature_mem[idx_addr] <= req_ff.feature_id;
      end
      if (cmd.load) begin
         feat_rd_ff <= feature_mem[ld_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.set_pending | cmd.set_assigned) begin
         value_mem[idx_addr] <= value_wd;
      end
      if (cmd.load) begin
         value_rd_ff <= value_mem[ld_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff      <= req_data;
         in_range_ff <= (32'(req_data.joint_index) < 32'(TABLE_DEPTH));
      end
      if (cmd.set_assigned) begin
         joint_ff <= joint_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff <= '0;
         next_joint_ff <= '0;
      end else begin
         if (cmd.clear_step) begin
            clear_addr_ff <= clear_addr_ff + ADDR_W'(1);
         end
         if (cmd.set_assigned) begin
            next_joint_ff <= next_joint_ff + jpf_pkg::COUNTER_W'(1);
         end
      end
   end

   assign joint_sel = (tag_rd_ff == jpf_pkg::TAG_PENDING) ?
                      next_joint_ff[jpf_pkg::JOINT_W-1:0] :
                      value_rd_ff[jpf_pkg::JOINT_W-1:0];

   always_comb begin
      rsp_in        = rsp_ff;
      rsp_strobe_in = cmd.emit_held | cmd.emit_now | cmd.emit_later;
      if (cmd.emit_held) begin
         rsp_in = '{assigned_joint: joint_sel, out_feature: feat_rd_ff,
                    out_point: value_rd_ff, last: 1'b0};
      end else if (cmd.emit_now) begin
         rsp_in = '{assigned_joint: joint_sel, out_feature: req_ff.feature_id,
                    out_point: req_ff.point_id, last: 1'b1};
      end else if (cmd.emit_later) begin
         rsp_in = '{assigned_joint: joint_ff, out_feature: req_ff.feature_id,
                    out_point: req_ff.point_id, last: 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign status.clear_last = (clear_addr_ff == LastAddr);
   assign status.in_range   = in_range_ff;
   assign status.tag        = tag_rd_ff;

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // the counter moves only when a pending entry is confirmed
   assert property (@(posedge clock) disable iff (reset)
      !cmd.set_assigned |=> $stable(next_joint_ff))
      else $error("joint counter moved without an assignment");

   // an entry is never held and confirmed in the same cycle
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.set_pending && cmd.set_assigned))
      else $error("pending and assigned writes collide");

   // a held point goes out together with its confirmation
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit_held |-> cmd.set_assigned)
      else $error("held point emitted without assignment");

endmodule

// ===== src/joint_pairing_filter.sv =====
// ----------------------------------------------------------------------------
// joint_pairing_filter: keep joints shared by two or more points
// Numbers confirmed joints densely and drops joints seen only once.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge with start high and busy low. Each
// request passes through the idle state that takes it and one lookup
// state, and through a third state when it confirms a pending joint and two
// responses leave; the table memory is read when the request is taken and
// written in the lookup state. Responses appear on rsp_data, flagged by
// rsp_strobe for exactly one cycle, and cannot be held off; the second
// response of a pair follows in the very next cycle and carries last.
// After reset the block clears the tag store one entry a cycle and keeps busy
// high until all min(TABLE_DEPTH, 65536) entries are clear.
// Joint indexes of TABLE_DEPTH or more are taken and dropped silently.
// ----------------------------------------------------------------------------
module joint_pairing_filter #(
   parameter int TABLE_DEPTH = 65536
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  jpf_pkg::req_type  req_data,
   output logic              rsp_strobe,
   output jpf_pkg::rsp_type  rsp_data
);

   jpf_pkg::cmd_type    cmd;
   jpf_pkg::status_type status;

   // sequencer: clearing pass, request intake, response ordering
   jpf_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   // stores, counter and response register
   jpf_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // a taken request always occupies the block for its lookup cycle
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request taken without entering lookup");

   // the first response of a pair is always followed by its final one
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last |=> rsp_strobe && rsp_data.last)
      else $error("pair of responses broken");

   // a final response leaves a gap before the next request can answer
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last |=> !rsp_strobe)
      else $error("response directly after a final response");

endmodule
